>>> src/crsm_pkg.sv
// ----------------------------------------------------------------------------
// crsm_pkg: shared types and constants of the contiguous ring space manager
// Operation codes, the packed result layout and reset defaults.
// ----------------------------------------------------------------------------
package crsm_pkg;

    localparam int CRSM_INDEX_BITS = 16;
    localparam int FIELD_W         = 16;
    localparam int MODE_W          = 3;
    localparam int CAP_W           = 16;
    localparam logic [CAP_W-1:0] CAP_RESET = 16'd4096;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC        = 3'd0,
        MODE_PREP_READ    = 3'd1,
        MODE_COMMIT_WR    = 3'd2,
        MODE_COMMIT_RD    = 3'd3,
        MODE_ROLLBACK_WR  = 3'd4,
        MODE_ROLLBACK_RD  = 3'd5
    } crsm_mode_t;

    // Packed so that alloc_ok sits in the lowest bit.
    typedef struct packed {
        logic [FIELD_W-1:0] second_length;
        logic [FIELD_W-1:0] first_length;
        logic [FIELD_W-1:0] first_start;
        logic [1:0]         segment_count;
        logic [FIELD_W-1:0] pending_count;
        logic [FIELD_W-1:0] start_index;
        logic               alloc_ok;
    } crsm_result_t;

    localparam int RESULT_W = $bits(crsm_result_t);

endpackage

>>> src/crsm_core.sv
// ----------------------------------------------------------------------------
// crsm_core: single-pass operation logic
// Computes the result and the next index/slack state for one request.
// ----------------------------------------------------------------------------
module crsm_core #(
    parameter int INDEX_BITS = crsm_pkg::CRSM_INDEX_BITS
) (
    input  crsm_pkg::crsm_mode_t          mode,
    input  logic [crsm_pkg::FIELD_W-1:0]  request_count,
    input  logic [crsm_pkg::CAP_W-1:0]    capacity,
    input  logic [INDEX_BITS:0]           wt,
    input  logic [INDEX_BITS:0]           wc,
    input  logic [INDEX_BITS-1:0]         rt,
    input  logic [INDEX_BITS-1:0]         rc,
    input  logic [INDEX_BITS-1:0]         st,
    input  logic [INDEX_BITS-1:0]         sc,
    output logic [INDEX_BITS:0]           wt_next,
    output logic [INDEX_BITS:0]           wc_next,
    output logic [INDEX_BITS-1:0]         rt_next,
    output logic [INDEX_BITS-1:0]         rc_next,
    output logic [INDEX_BITS-1:0]         st_next,
    output logic [INDEX_BITS-1:0]         sc_next,
    output crsm_pkg::crsm_result_t        result
);

    // Working width covers index sums and 16-bit fields with headroom.
    localparam int SW = ((INDEX_BITS > crsm_pkg::FIELD_W) ? INDEX_BITS : crsm_pkg::FIELD_W) + 2;
    localparam logic [SW-1:0]       POS_MASK  = SW'({INDEX_BITS{1'b1}});
    localparam logic [INDEX_BITS:0] FULL_MARK = {(INDEX_BITS+1){1'b1}};

    logic [SW-1:0] cap_raw, cap_x, wt_x, wc_x, rc_x, sc_x, n_x;
    logic [SW-1:0] wsum, wnew, start_x, slack_x;
    logic [SW-1:0] effc, till, wrap_sum, pending, first_len, second_len;
    logic          wt_full, wc_full, ok;

    assign cap_raw = SW'(capacity);
    assign cap_x   = (cap_raw < POS_MASK) ? cap_raw : POS_MASK;
    assign wt_x    = SW'(wt);
    assign wc_x    = SW'(wc);
    assign rc_x    = SW'(rc);
    assign sc_x    = SW'(sc);
    assign n_x     = SW'(request_count);
    assign wt_full = (wt == FULL_MARK);
    assign wc_full = (wc == FULL_MARK);
    assign wsum    = wt_x + n_x;
    assign slack_x = (cap_x > wt_x) ? (cap_x - wt_x) : '0;

    // Allocation: fit in the tail, else wrap to slot 0 if the reader left room.
    always_comb begin
        ok      = 1'b0;
        start_x = '0;
        wnew    = wt_x;
        if (wt_full) begin
            ok = 1'b0;
        end else if (wt_x >= rc_x) begin
            if (cap_x >= wsum) begin
                ok      = 1'b1;
                start_x = wt_x;
                wnew    = wsum;
            end else if (rc_x >= n_x) begin
                ok      = 1'b1;
                start_x = '0;
                wnew    = n_x;
            end
        end else if (rc_x >= wsum) begin
            ok      = 1'b1;
            start_x = wt_x;
            wnew    = wsum;
        end
    end

    // Read span from the committed copies.
    assign effc     = (cap_x > sc_x) ? (cap_x - sc_x) : '0;
    assign till     = (effc > rc_x) ? (effc - rc_x) : '0;
    assign wrap_sum = effc + wc_x;

    always_comb begin
        if (wc_full) begin
            pending = effc;
        end else if (wc_x >= rc_x) begin
            pending = wc_x - rc_x;
        end else begin
            pending = (wrap_sum > rc_x) ? (wrap_sum - rc_x) : '0;
        end
    end

    always_comb begin
        wt_next = wt;
        wc_next = wc;
        rt_next = rt;
        rc_next = rc;
        st_next = st;
        sc_next = sc;
        result  = '0;
        first_len  = '0;
        second_len = '0;
        unique case (mode)
            crsm_pkg::MODE_ALLOC: begin
                if (ok) begin
                    if ((wnew == rc_x) && (request_count != '0)) begin
                        wt_next = FULL_MARK;
                    end else begin
                        wt_next = {1'b0, wnew[INDEX_BITS-1:0]};
                    end
                    // Only the wrap path leaves slack behind.
                    if ((wt_x >= rc_x) && (cap_x < wsum)) begin
                        st_next = slack_x[INDEX_BITS-1:0];
                    end
                end
                result.alloc_ok    = ok;
                result.start_index = start_x[crsm_pkg::FIELD_W-1:0];
            end
            crsm_pkg::MODE_PREP_READ: begin
                if (pending == '0) begin
                    result.segment_count = 2'd0;
                end else if ((rc_x + pending) <= effc) begin
                    result.segment_count = 2'd1;
                    first_len = pending;
                end else begin
                    result.segment_count = 2'd2;
                    first_len  = till;
                    second_len = (pending > till) ? (pending - till) : '0;
                end
                if (wt_full) begin
                    wt_next = {1'b0, rt};
                end
                if (pending < till) begin
                    rt_next = INDEX_BITS'(rc_x + pending);
                end else begin
                    rt_next = INDEX_BITS'(pending - till);
                end
                result.pending_count = pending[crsm_pkg::FIELD_W-1:0];
                result.first_start   = rc_x[crsm_pkg::FIELD_W-1:0];
                result.first_length  = first_len[crsm_pkg::FIELD_W-1:0];
                result.second_length = second_len[crsm_pkg::FIELD_W-1:0];
            end
            crsm_pkg::MODE_COMMIT_WR: begin
                if (wt < wc) sc_next = st;
                wc_next = wt;
            end
            crsm_pkg::MODE_COMMIT_RD: begin
                if (rt < rc) sc_next = st;
                rc_next = rt;
            end
            crsm_pkg::MODE_ROLLBACK_WR: begin
                if (wt < wc) st_next = sc;
                wt_next = wc;
            end
            crsm_pkg::MODE_ROLLBACK_RD: begin
                if (rt < rc) st_next = sc;
                rt_next = rc;
            end
            default: begin
                result = '0;
            end
        endcase
    end

endmodule

>>> src/contiguous_ring_space_manager.sv
// A request passes the input register, then the result register, before m_tvalid rises;
// a result that waits untaken holds the next request in the input register.
// Throughput: 1 request per cycle while results are taken; the operation logic is one
// combinational pass between the input and result registers, which also updates the indices.
// The result register decouples the sides: a new request is taken while a result waits.
// Reset (aresetn low, synchronous): all indices and slack clear to 0, capacity to 4096.
// ----------------------------------------------------------------------------
// contiguous_ring_space_manager: top level
// Contiguous ring allocator with tentative/committed indices, commit and rollback.
// ----------------------------------------------------------------------------
module contiguous_ring_space_manager #(
    parameter int INDEX_BITS = crsm_pkg::CRSM_INDEX_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,

    // capacity write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,       // [15:0] capacity

    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,        // [2:0] mode, [18:3] request_count, [23:19] zero

    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata         // [0] alloc_ok, [16:1] start_index,
                                        // [32:17] pending_count, [34:33] segment_count,
                                        // [50:35] first_start, [66:51] first_length,
                                        // [82:67] second_length, [87:83] zero
);

    localparam logic [INDEX_BITS:0] FULL_MARK = {(INDEX_BITS+1){1'b1}};
    localparam logic [INDEX_BITS:0] POS_MAX   = {1'b0, {INDEX_BITS{1'b1}}};

    // Capacity register, always ready; write it only while idle (not enforced by the block).
    logic [crsm_pkg::CAP_W-1:0] cap_reg;

    // Input register
    logic                          in_valid_reg;
    crsm_pkg::crsm_mode_t          mode_reg;
    logic [crsm_pkg::FIELD_W-1:0]  count_reg;

    // Ring state: tentative and committed copies
    logic [INDEX_BITS:0]   wt_reg, wc_reg, wt_next, wc_next;
    logic [INDEX_BITS-1:0] rt_reg, rc_reg, rt_next, rc_next;
    logic [INDEX_BITS-1:0] st_reg, sc_reg, st_next, sc_next;

    // Result register
    logic                     m_valid_reg;
    crsm_pkg::crsm_result_t   res_reg, res_next;

    logic advance;

    // The request in the input register is executed in the cycle it moves on.
    assign advance   = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {{(88 - crsm_pkg::RESULT_W){1'b0}}, res_reg};

    crsm_core #(
        .INDEX_BITS (INDEX_BITS)
    ) u_core (
        .mode          (mode_reg),
        .request_count (count_reg),
        .capacity      (cap_reg),
        .wt            (wt_reg),
        .wc            (wc_reg),
        .rt            (rt_reg),
        .rc            (rc_reg),
        .st            (st_reg),
        .sc            (sc_reg),
        .wt_next       (wt_next),
        .wc_next       (wc_next),
        .rt_next       (rt_next),
        .rc_next       (rc_next),
        .st_next       (st_next),
        .sc_next       (sc_next),
        .result        (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg      <= crsm_pkg::CAP_RESET;
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            wt_reg       <= '0;
            wc_reg       <= '0;
            rt_reg       <= '0;
            rc_reg       <= '0;
            st_reg       <= '0;
            sc_reg       <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                cap_reg <= cfg_data;
            end
            // Input stage fills on accept, drains on advance.
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            // Result stage
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            // State commits together with the result.
            if (advance) begin
                wt_reg <= wt_next;
                wc_reg <= wc_next;
                rt_reg <= rt_next;
                rc_reg <= rc_next;
                st_reg <= st_next;
                sc_reg <= sc_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            mode_reg  <= crsm_pkg::crsm_mode_t'(s_tdata[2:0]);
            count_reg <= s_tdata[18:3];
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    // Write indices are either a ring position or the full mark.
    a_wt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (wt_reg == FULL_MARK) || (wt_reg <= POS_MAX))
        else $error("tentative write index out of range");

    a_wc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (wc_reg == FULL_MARK) || (wc_reg <= POS_MAX))
        else $error("committed write index out of range");

    // A successful allocate result never carries read-span fields.
    a_alloc_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res_reg.alloc_ok) |->
            (res_reg.segment_count == 2'd0 && res_reg.pending_count == '0))
        else $error("allocate result carries read span");

    // An accepted request occupies the input register next cycle.
    a_accept_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> in_valid_reg)
        else $error("accepted request lost");

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the contiguous ring space manager
// Sends requests (allocate, prepare read, commits, rollbacks) with random
// gaps and result stalls across several ring capacities. Every accepted
// request is run through a local copy of the ring indices. Each result is
// checked against the oldest expected reply, field by field.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int REPORT_LIMIT = 10;
    localparam int FULL_POS     = 32'h1FFFF;   // write index meeting the read index
    localparam logic [crsm_pkg::MODE_W-1:0] MODE_UNUSED_A = 3'd6;
    localparam logic [crsm_pkg::MODE_W-1:0] MODE_UNUSED_B = 3'd7;

    // request fields, mode in the low bits as on s_tdata
    typedef struct packed {
        logic [15:0]                 count;
        logic [crsm_pkg::MODE_W-1:0] mode;
    } ring_op_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [87:0] m_tdata;

    // local copy of the ring state
    logic [15:0] ring_cap   = crsm_pkg::CAP_RESET;
    logic [16:0] wr_tent    = '0;
    logic [16:0] wr_comm    = '0;
    logic [15:0] rd_tent    = '0;
    logic [15:0] rd_comm    = '0;
    logic [15:0] slack_tent = '0;
    logic [15:0] slack_comm = '0;

    ring_op_t               op_backlog[$];
    crsm_pkg::crsm_result_t ring_replies[$];

    int  tx_idle_max = 0;
    int  rx_idle_max = 0;
    int  mismatch_cnt = 0;
    int  cycle_cnt = 0;
    logic hold_phase = 1'b0;
    logic hold_done  = 1'b0;

    contiguous_ring_space_manager DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int sat_sub(input int a, input int b);
        return (a > b) ? a - b : 0;
    endfunction

    // Applies one request to the local ring state and returns its reply.
    function automatic crsm_pkg::crsm_result_t advance_ring(input ring_op_t op);
        crsm_pkg::crsm_result_t r;
        int cap, wt, wc, rc, n, effc, till, pend;
        r    = '0;
        cap  = ring_cap;
        wt   = wr_tent;
        wc   = wr_comm;
        rc   = rd_comm;
        n    = op.count;
        case (op.mode)
            crsm_pkg::MODE_ALLOC: begin
                if (wt >= rc && wt != FULL_POS) begin
                    if (cap >= wt + n) begin
                        r.alloc_ok    = 1'b1;
                        r.start_index = 16'(wt);
                        wt            = wt + n;
                    end else if (rc >= n) begin
                        // tail too short: restart at slot 0, tail becomes slack
                        slack_tent    = 16'(sat_sub(cap, wt));
                        r.alloc_ok    = 1'b1;
                        wt            = n;
                    end
                end else if (wt < rc && rc >= wt + n) begin
                    r.alloc_ok    = 1'b1;
                    r.start_index = 16'(wt);
                    wt            = wt + n;
                end
                if (r.alloc_ok)
                    wr_tent = (wt == rc && n > 0) ? 17'(FULL_POS) : 17'(wt);
            end
            crsm_pkg::MODE_PREP_READ: begin
                effc = sat_sub(cap, slack_comm);
                till = sat_sub(effc, rc);
                if (wc == FULL_POS)
                    pend = effc;
                else if (wc >= rc)
                    pend = wc - rc;
                else
                    pend = sat_sub(effc + wc, rc);
                if (pend != 0) begin
                    if (rc + pend <= effc) begin
                        r.segment_count = 2'd1;
                        r.first_length  = 16'(pend);
                    end else begin
                        r.segment_count = 2'd2;
                        r.first_length  = 16'(till);
                        r.second_length = 16'(sat_sub(pend, till));
                    end
                end
                if (wr_tent == 17'(FULL_POS))
                    wr_tent = {1'b0, rd_tent};
                rd_tent = (pend < till) ? 16'(rc + pend) : 16'(pend - till);
                r.pending_count = 16'(pend);
                r.first_start   = 16'(rc);
            end
            crsm_pkg::MODE_COMMIT_WR: begin
                if (wr_tent < wr_comm)
                    slack_comm = slack_tent;
                wr_comm = wr_tent;
            end
            crsm_pkg::MODE_COMMIT_RD: begin
                if (rd_tent < rd_comm)
                    slack_comm = slack_tent;
                rd_comm = rd_tent;
            end
            crsm_pkg::MODE_ROLLBACK_WR: begin
                if (wr_tent < wr_comm)
                    slack_tent = slack_comm;
                wr_tent = wr_comm;
            end
            crsm_pkg::MODE_ROLLBACK_RD: begin
                if (rd_tent < rd_comm)
                    slack_tent = slack_comm;
                rd_tent = rd_comm;
            end
            default: ;
        endcase
        return r;
    endfunction

    // Request sender: offers queued requests, predicts each one taken.
    always @(posedge aclk) begin : tx_drive
        ring_op_t taken;
        logic     offering;
        int       tx_wait;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_wait  = 0;
        end else begin
            offering = s_tvalid;
            if (s_tvalid && s_tready) begin
                taken = s_tdata[$bits(ring_op_t)-1:0];
                ring_replies.push_back(advance_ring(taken));
                offering = 1'b0;
            end
            if (!offering) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                end else if (op_backlog.size() != 0) begin
                    s_tdata  <= {5'b0, op_backlog.pop_front()};
                    offering = 1'b1;
                    tx_wait  = $urandom_range(0, tx_idle_max);
                end
            end
            s_tvalid <= offering;
        end
    end

    // Result receiver: checks each taken result, then draws its next stall.
    always @(posedge aclk) begin : rx_check
        crsm_pkg::crsm_result_t got, want;
        int                     rx_wait;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait  = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[crsm_pkg::RESULT_W-1:0];
                if (ring_replies.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_LIMIT)
                        $display("unexpected result %h at cycle %0d", got, cycle_cnt);
                end else begin
                    want = ring_replies.pop_front();
                    if (got.alloc_ok !== want.alloc_ok
                            || got.start_index !== want.start_index
                            || got.pending_count !== want.pending_count
                            || got.segment_count !== want.segment_count
                            || got.first_start !== want.first_start
                            || got.first_length !== want.first_length
                            || got.second_length !== want.second_length) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= REPORT_LIMIT) begin
                            $display("mismatch at cycle %0d (ok start pend segs fst flen slen)",
                                     cycle_cnt);
                            $display("  expected %0d %0d %0d %0d %0d %0d %0d",
                                     want.alloc_ok, want.start_index, want.pending_count,
                                     want.segment_count, want.first_start,
                                     want.first_length, want.second_length);
                            $display("  actual   %0d %0d %0d %0d %0d %0d %0d",
                                     got.alloc_ok, got.start_index, got.pending_count,
                                     got.segment_count, got.first_start,
                                     got.first_length, got.second_length);
                        end
                    end
                end
                rx_wait = $urandom_range(0, rx_idle_max);
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            m_tready <= !(hold_phase && !hold_done) && rx_wait == 0;
        end
    end

    // Long result hold-off so the block fills and stalls its input.
    initial begin : rx_hold_off
        wait (hold_phase);
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_done <= 1'b1;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("[contiguous_ring_space_manager] ERROR");
            $finish;
        end
    end

    task automatic push_op(input logic [crsm_pkg::MODE_W-1:0] mode, input logic [15:0] count);
        ring_op_t op;
        op.mode  = mode;
        op.count = count;
        op_backlog.push_back(op);
    endtask

    // Waits until no request is queued or in flight, then a few idle cycles.
    // Checked at the falling edge so the driver's updates have landed.
    task automatic settle();
        @(negedge aclk);
        while (op_backlog.size() != 0 || s_tvalid || ring_replies.size() != 0)
            @(negedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [15:0] cap);
        @(posedge aclk);
        cfg_data  <= cap;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        ring_cap  = cap;
    endtask

    // Record counts scaled to the ring, with zero, exact fill and wild values.
    function automatic logic [15:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)
            return 16'($urandom());
        if (r < 12)
            return 16'd0;
        if (r < 18)
            return ring_cap + 16'($urandom_range(0, 1));
        return 16'($urandom_range(1, ring_cap / 3 + 1));
    endfunction

    // Mostly allocate/commit and prepare/commit sequences, some noise.
    task automatic queue_traffic(input int n_items);
        int made, k, r;
        made = 0;
        while (made < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                k = $urandom_range(1, 3);
                repeat (k) push_op(crsm_pkg::MODE_ALLOC, pick_count());
                push_op(($urandom_range(0, 5) == 0) ? crsm_pkg::MODE_ROLLBACK_WR
                                                    : crsm_pkg::MODE_COMMIT_WR,
                        16'($urandom()));
                made += k + 1;
            end else if (r < 88) begin
                push_op(crsm_pkg::MODE_PREP_READ, 16'($urandom()));
                push_op(($urandom_range(0, 5) == 0) ? crsm_pkg::MODE_ROLLBACK_RD
                                                    : crsm_pkg::MODE_COMMIT_RD,
                        16'($urandom()));
                made += 2;
            end else begin
                push_op(3'($urandom_range(0, 7)), 16'($urandom()));
                made += 1;
            end
        end
    endtask

    initial begin : stimulus
        logic [15:0] caps[10];
        caps = '{16'd16, 16'd65535, 16'd4096, 16'd2, 16'($urandom_range(2, 65535)),
                 16'd3, 16'd500, 16'($urandom_range(2, 65535)), 16'd65535, 16'd2};

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        settle();

        // reset capacity: empty ring, zero and oversize allocs, spare modes
        push_op(crsm_pkg::MODE_PREP_READ, 16'd0);
        push_op(crsm_pkg::MODE_ALLOC, 16'd0);
        push_op(crsm_pkg::MODE_ALLOC, 16'hFFFF);
        push_op(MODE_UNUSED_A, 16'hFFFF);
        push_op(MODE_UNUSED_B, 16'h5A5A);
        push_op(crsm_pkg::MODE_ROLLBACK_WR, 16'd0);
        push_op(crsm_pkg::MODE_ROLLBACK_RD, 16'd0);
        settle();

        // tiny ring: wrap with slack, fill to full, two-segment read
        write_capacity(16'd8);
        push_op(crsm_pkg::MODE_ALLOC, 16'd5);
        push_op(crsm_pkg::MODE_COMMIT_WR, 16'd0);
        push_op(crsm_pkg::MODE_PREP_READ, 16'd0);
        push_op(crsm_pkg::MODE_COMMIT_RD, 16'd0);
        push_op(crsm_pkg::MODE_ALLOC, 16'd4);
        push_op(crsm_pkg::MODE_ALLOC, 16'd1);
        push_op(crsm_pkg::MODE_ALLOC, 16'd0);
        push_op(crsm_pkg::MODE_COMMIT_WR, 16'd0);
        push_op(crsm_pkg::MODE_PREP_READ, 16'd0);
        push_op(crsm_pkg::MODE_COMMIT_RD, 16'd0);
        push_op(crsm_pkg::MODE_ROLLBACK_WR, 16'd0);
        push_op(crsm_pkg::MODE_ALLOC, 16'd2);
        push_op(crsm_pkg::MODE_PREP_READ, 16'd0);
        settle();

        // shrink below the indices: write and read index beyond capacity
        write_capacity(16'd2);
        push_op(crsm_pkg::MODE_ALLOC, 16'd1);
        push_op(crsm_pkg::MODE_COMMIT_WR, 16'd0);
        push_op(crsm_pkg::MODE_PREP_READ, 16'd0);
        push_op(crsm_pkg::MODE_COMMIT_RD, 16'd0);
        settle();

        foreach (caps[i]) begin
            write_capacity(caps[i]);
            if (i == 2) begin
                // sender keeps offering while the receiver holds off
                tx_idle_max = 0;
                rx_idle_max = 0;
                @(posedge aclk);
                hold_phase <= 1'b1;
            end else begin
                tx_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 19;
                rx_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 19;
            end
            queue_traffic(112);
            settle();
        end

        repeat (10) @(posedge aclk);
        if (mismatch_cnt == 0)
            $display("[contiguous_ring_space_manager] OK");
        else
            $display("[contiguous_ring_space_manager] ERROR");
        $finish;
    end

endmodule
